/* rtl/core/mlds_pkg.sv */
package mlds_pkg;

    localparam int LANES     = 16;
    localparam int LANE_W    = 32;
    localparam int KEY_LANE  = 15;
    localparam int DIST_W    = 5;
    localparam int NUM_W     = 10;
    localparam int TENSION_W = 15;

    localparam logic [TENSION_W-1:0] TENSION_MAX = 15'd16384;
    localparam logic [DIST_W-1:0]    NO_MIN      = 5'd31;
    localparam logic [1:0]           SPIKE_SAT   = 2'd2;

    // Both internal queues hold two entries.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic REQ_QUERY = 1'b0;

    typedef enum logic [1:0] {
        CFG_SECRET_MASK = 2'd0,
        CFG_SPIKE_THR   = 2'd1,
        CFG_REJECT_THR  = 2'd2,
        CFG_GUARD_EN    = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        STATUS_RESOLVED = 2'd0,
        STATUS_NO_MATCH = 2'd1,
        STATUS_SPIKE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_QUERY      = 2'd0,
        KIND_QUERY_LAST = 2'd1,
        KIND_ATOM       = 2'd2,
        KIND_ATOM_LAST  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [LANE_W-1:0] secret_mask;
        logic [DIST_W-1:0] spike_threshold;
        logic [DIST_W-1:0] rejection_threshold;
        logic              spike_guard_enable;
    } t_cfg;

    typedef struct packed {
        t_kind                        kind;
        logic [LANE_W-1:0]            key;
        logic [LANES-1:0][LANE_W-1:0] lanes;
    } t_work;

    typedef struct packed {
        logic [DIST_W-1:0]    atom_distance;
        logic                 key_matched;
        logic [NUM_W-1:0]     atom_number;
        logic                 done_res;
        t_status              status;
        logic [NUM_W-1:0]     best_index;
        logic [TENSION_W-1:0] tension;
    } t_result;

endpackage

/* rtl/core/mlds_front.sv */
module mlds_front
    import mlds_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [LANE_W-1:0]            i_secret_mask,
    input  logic                         i_push,
    input  logic                         i_req_type,
    input  logic [LANES-1:0][LANE_W-1:0] i_lanes,
    input  logic [LANE_W-1:0]            i_atom_key,
    input  logic                         i_last,
    output logic                         o_full,
    output logic                         o_valid,
    output t_work                        o_work,
    input  logic                         i_take
);

    t_work               r_buf [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    t_work               w_entry;
    logic                w_push;
    logic                w_pop;

    // The key is masked here; the user changes the mask only while no item is in flight; the block does not enforce it.
    always_comb begin
        unique case ({i_req_type, i_last})
            {REQ_QUERY, 1'b0}:  w_entry.kind = KIND_QUERY;
            {REQ_QUERY, 1'b1}:  w_entry.kind = KIND_QUERY_LAST;
            {~REQ_QUERY, 1'b0}: w_entry.kind = KIND_ATOM;
            default:            w_entry.kind = KIND_ATOM_LAST;
        endcase
        if (i_req_type == REQ_QUERY) begin
            w_entry.key = i_lanes[KEY_LANE] & i_secret_mask;
        end else begin
            w_entry.key = i_atom_key & i_secret_mask;
        end
        w_entry.lanes = i_lanes;
    end

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_buf[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(w_push) - Q_CNT_W'(w_pop);
        end
    end

endmodule

/* rtl/core/mlds_back.sv */
module mlds_back
    import mlds_pkg::*;
#(
    parameter int MAX_ATOMS = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_work   i_work,
    output logic    o_take,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam int CNT_W = $clog2(MAX_ATOMS);

    logic [LANES-1:0][LANE_W-1:0] r_query_lanes;
    logic [DIST_W-1:0]            r_min;
    logic [CNT_W-1:0]             r_best;
    logic [TENSION_W-1:0]         r_tension;
    logic [1:0]                   r_tally;
    logic [CNT_W-1:0]             r_atom_cnt;

    logic [DIST_W-1:0]            n_min;
    logic [CNT_W-1:0]             n_best;
    logic [TENSION_W-1:0]         n_tension;
    logic [1:0]                   n_tally;
    logic [CNT_W-1:0]             n_atom_cnt;

    t_result                      r_out [Q_DEPTH];
    logic [Q_PTR_W-1:0]           r_wr_ptr;
    logic [Q_PTR_W-1:0]           r_rd_ptr;
    logic [Q_CNT_W-1:0]           r_count;

    logic [LANES-1:0]             w_lane_diff;
    logic                         w_matched;
    logic [DIST_W-1:0]            w_dist;
    logic [TENSION_W:0]           w_sum;
    logic [CNT_W+NUM_W-1:0]       w_num_wide;
    logic [CNT_W+NUM_W-1:0]       w_best_wide;
    logic                         w_out_full;
    logic                         w_is_query;
    logic                         w_is_last;
    logic                         w_push;
    logic                         w_pop;
    t_status                      w_status;
    t_result                      w_result;

    assign w_is_query = (i_work.kind == KIND_QUERY) || (i_work.kind == KIND_QUERY_LAST);
    assign w_is_last  = (i_work.kind == KIND_QUERY_LAST) || (i_work.kind == KIND_ATOM_LAST);
    assign w_out_full = (r_count == Q_CNT_W'(Q_DEPTH));

    // A query without last makes no result, so it never waits on the output queue.
    assign o_take = i_valid && (!w_out_full || i_work.kind == KIND_QUERY);
    assign w_push = o_take && (i_work.kind != KIND_QUERY);
    assign w_pop  = i_pop && !o_empty;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_lane_diff[i] = (i_work.lanes[i] != r_query_lanes[i]);
        end
        // The query key is masked here, since the mask may change between a query
        // and the atoms that follow it.
        w_matched = (i_work.key == (r_query_lanes[KEY_LANE] & i_cfg.secret_mask));
        w_dist    = w_matched ? DIST_W'($countones(w_lane_diff)) : '0;
        w_sum     = {1'b0, r_tension} + (TENSION_W+1)'(w_dist);

        n_min      = r_min;
        n_best     = r_best;
        n_tension  = r_tension;
        n_tally    = r_tally;
        n_atom_cnt = r_atom_cnt;
        if (w_matched) begin
            n_tension = (w_sum > {1'b0, TENSION_MAX}) ? TENSION_MAX : w_sum[TENSION_W-1:0];
            if (w_dist <= i_cfg.spike_threshold && r_tally < SPIKE_SAT) begin
                n_tally = r_tally + 2'd1;
            end
            if (w_dist < r_min) begin
                n_min  = w_dist;
                n_best = r_atom_cnt;
            end
        end
        if (r_atom_cnt < CNT_W'(MAX_ATOMS - 1)) begin
            n_atom_cnt = r_atom_cnt + 1'b1;
        end

        if (i_cfg.spike_guard_enable && n_tally >= SPIKE_SAT) begin
            w_status = STATUS_SPIKE;
        end else if (n_min == NO_MIN || n_min > i_cfg.rejection_threshold) begin
            w_status = STATUS_NO_MATCH;
        end else begin
            w_status = STATUS_RESOLVED;
        end

        w_num_wide  = {{NUM_W{1'b0}}, r_atom_cnt};
        w_best_wide = {{NUM_W{1'b0}}, n_best};

        w_result = '0;
        w_result.status = STATUS_RESOLVED;
        if (w_is_query) begin
            w_result.done_res = 1'b1;
            w_result.status   = STATUS_NO_MATCH;
        end else begin
            w_result.atom_distance = w_dist;
            w_result.key_matched   = w_matched;
            w_result.atom_number   = w_num_wide[NUM_W-1:0];
            if (w_is_last) begin
                w_result.done_res = 1'b1;
                w_result.status   = w_status;
                w_result.tension  = n_tension;
                if (w_status == STATUS_RESOLVED) begin
                    w_result.best_index = w_best_wide[NUM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_lanes <= '0;
            r_min         <= NO_MIN;
            r_best        <= '0;
            r_tension     <= '0;
            r_tally       <= '0;
            r_atom_cnt    <= '0;
        end else if (o_take) begin
            if (w_is_query || w_is_last) begin
                r_min      <= NO_MIN;
                r_best     <= '0;
                r_tension  <= '0;
                r_tally    <= '0;
                r_atom_cnt <= '0;
            end else begin
                r_min      <= n_min;
                r_best     <= n_best;
                r_tension  <= n_tension;
                r_tally    <= n_tally;
                r_atom_cnt <= n_atom_cnt;
            end
            if (w_is_query) begin
                r_query_lanes <= i_work.lanes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out[r_wr_ptr] <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(w_push) - Q_CNT_W'(w_pop);
        end
    end

    assign o_empty  = (r_count == '0);
    assign o_result = r_out[r_rd_ptr];

endmodule

/* rtl/core/masked_lane_distance_min_search.sv */
// One item is accepted per clock cycle while full is low; items are registered in the
// input queue, results in the output queue. The compare, lane count and running
// minimum per atom are combinational in the search engine between two 2-entry queues.
// Synchronous active-low reset empties both queues, restores the register defaults,
// zeroes the query lanes and clears the search state. No clearing pass is needed.
module masked_lane_distance_min_search
    import mlds_pkg::*;
#(
    parameter int MAX_ATOMS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [LANE_W-1:0]     i_cfg_data,

    input  logic                  push,
    output logic                  full,
    input  logic                  i_req_type,
    input  logic [63:0]           i_lanes_0_1,
    input  logic [63:0]           i_lanes_2_3,
    input  logic [63:0]           i_lanes_4_5,
    input  logic [63:0]           i_lanes_6_7,
    input  logic [63:0]           i_lanes_8_9,
    input  logic [63:0]           i_lanes_10_11,
    input  logic [63:0]           i_lanes_12_13,
    input  logic [63:0]           i_lanes_14_15,
    input  logic [LANE_W-1:0]     i_atom_key,
    input  logic                  i_last,

    output logic                  empty,
    input  logic                  pop,
    output logic [DIST_W-1:0]     o_atom_distance,
    output logic                  o_key_matched,
    output logic [NUM_W-1:0]      o_atom_number,
    output logic                  o_done_res,
    output logic [1:0]            o_status,
    output logic [NUM_W-1:0]      o_best_index,
    output logic [TENSION_W-1:0]  o_tension
);

    t_cfg                         r_cfg;
    logic [LANES-1:0][LANE_W-1:0] w_lanes;
    logic                         w_valid;
    logic                         w_take;
    t_work                        w_work;
    t_result                      w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.secret_mask         <= '1;
            r_cfg.spike_threshold     <= '0;
            r_cfg.rejection_threshold <= 5'd8;
            r_cfg.spike_guard_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SECRET_MASK: r_cfg.secret_mask         <= i_cfg_data;
                CFG_SPIKE_THR:   r_cfg.spike_threshold     <= i_cfg_data[DIST_W-1:0];
                CFG_REJECT_THR:  r_cfg.rejection_threshold <= i_cfg_data[DIST_W-1:0];
                default:         r_cfg.spike_guard_enable  <= i_cfg_data[0];
            endcase
        end
    end

    assign w_lanes = {i_lanes_14_15, i_lanes_12_13, i_lanes_10_11, i_lanes_8_9,
                      i_lanes_6_7, i_lanes_4_5, i_lanes_2_3, i_lanes_0_1};

    mlds_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_secret_mask (r_cfg.secret_mask),
        .i_push        (push),
        .i_req_type    (i_req_type),
        .i_lanes       (w_lanes),
        .i_atom_key    (i_atom_key),
        .i_last        (i_last),
        .o_full        (full),
        .o_valid       (w_valid),
        .o_work        (w_work),
        .i_take        (w_take)
    );

    mlds_back #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_valid),
        .i_work   (w_work),
        .o_take   (w_take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (w_result)
    );

    assign o_atom_distance = w_result.atom_distance;
    assign o_key_matched   = w_result.key_matched;
    assign o_atom_number   = w_result.atom_number;
    assign o_done_res      = w_result.done_res;
    assign o_status        = w_result.status;
    assign o_best_index    = w_result.best_index;
    assign o_tension       = w_result.tension;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import mlds_pkg::*;

    localparam int MAX_ATOMS       = 1024;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 4;
    localparam int LONG_ATOMS      = 1028;
    localparam int SETTLE_CYCLES   = 4;
    localparam int STUCK_LIMIT     = 500;
    localparam bit REQ_ATOM        = ~REQ_QUERY;

    typedef bit [LANES-1:0][LANE_W-1:0] t_lanes;

    typedef struct {
        bit              req_type;
        t_lanes          lanes;
        bit [LANE_W-1:0] key;
        bit              last;
    } t_search_item;

    typedef struct {
        bit [LANE_W-1:0] mask;
        bit [DIST_W-1:0] spike;
        bit [DIST_W-1:0] reject;
        bit              guard;
    } t_knob_set;

    class min_search_scoreboard;
        t_lanes          ref_vector;
        int unsigned     low_dist;
        int unsigned     low_slot;
        int unsigned     dist_total;
        int unsigned     spike_hits;
        int unsigned     next_index;
        bit [LANE_W-1:0] key_mask;
        int unsigned     spike_level;
        int unsigned     reject_level;
        bit              guard_on;
        t_result         awaited_results[$];
        int unsigned     mismatches;
        int unsigned     results_checked;
        int unsigned     items_noted;
        int unsigned     queries_noted;
        int unsigned     status_seen[3];

        function new();
            key_mask     = '1;
            spike_level  = 0;
            reject_level = 8;
            guard_on     = 1'b0;
            ref_vector   = '0;
            clear_search();
        endfunction

        function void clear_search();
            low_dist    = NO_MIN;
            low_slot    = 0;
            dist_total  = 0;
            spike_hits  = 0;
            next_index  = 0;
        endfunction

        function void set_reg(t_cfg_index idx, bit [LANE_W-1:0] val);
            case (idx)
                CFG_SECRET_MASK: key_mask = val;
                CFG_SPIKE_THR:   spike_level = val[DIST_W-1:0];
                CFG_REJECT_THR:  reject_level = val[DIST_W-1:0];
                CFG_GUARD_EN:    guard_on = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40) begin
                $display("MISMATCH at %0t ns: %s", $time, msg);
            end
        endtask

        // Works out the result, if any, that one accepted item causes.
        task absorb_item(t_search_item it);
            t_result     r;
            int unsigned lane_miss;
            int unsigned slot;
            items_noted++;
            r = '0;
            if (it.req_type == REQ_QUERY) begin
                queries_noted++;
                ref_vector = it.lanes;
                clear_search();
                if (it.last) begin
                    r.done_res = 1'b1;
                    r.status   = STATUS_NO_MATCH;
                    awaited_results.push_back(r);
                end
                return;
            end
            slot = next_index;
            lane_miss = 0;
            if ((ref_vector[KEY_LANE] & key_mask) == (it.key & key_mask)) begin
                r.key_matched = 1'b1;
                for (int i = 0; i < LANES; i++) begin
                    if (it.lanes[i] != ref_vector[i]) lane_miss++;
                end
                dist_total += lane_miss;
                if (dist_total > TENSION_MAX) dist_total = TENSION_MAX;
                if (lane_miss <= spike_level && spike_hits < SPIKE_SAT) spike_hits++;
                if (lane_miss < low_dist) begin
                    low_dist = lane_miss;
                    low_slot = slot;
                end
            end
            if (next_index < MAX_ATOMS - 1) next_index++;
            r.atom_distance = DIST_W'(lane_miss);
            r.atom_number   = NUM_W'(slot);
            if (it.last) begin
                r.done_res = 1'b1;
                if (guard_on && spike_hits >= SPIKE_SAT) begin
                    r.status = STATUS_SPIKE;
                end else if (low_dist == NO_MIN || low_dist > reject_level) begin
                    r.status = STATUS_NO_MATCH;
                end else begin
                    r.status     = STATUS_RESOLVED;
                    r.best_index = NUM_W'(low_slot);
                end
                r.tension = TENSION_W'(dist_total);
                clear_search();
            end
            awaited_results.push_back(r);
        endtask

        task check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result arrived with none expected");
                return;
            end
            want = awaited_results.pop_front();
            results_checked++;
            if (want.done_res) status_seen[int'(want.status)]++;
            if (got.atom_distance !== want.atom_distance)
                report_mismatch($sformatf("atom_distance got %0d expected %0d",
                                          got.atom_distance, want.atom_distance));
            if (got.key_matched !== want.key_matched)
                report_mismatch($sformatf("key_matched got %0d expected %0d",
                                          got.key_matched, want.key_matched));
            if (got.atom_number !== want.atom_number)
                report_mismatch($sformatf("atom_number got %0d expected %0d",
                                          got.atom_number, want.atom_number));
            if (got.done_res !== want.done_res)
                report_mismatch($sformatf("done_res got %0d expected %0d",
                                          got.done_res, want.done_res));
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d expected %0d",
                                          got.status, want.status));
            if (got.best_index !== want.best_index)
                report_mismatch($sformatf("best_index got %0d expected %0d",
                                          got.best_index, want.best_index));
            if (got.tension !== want.tension)
                report_mismatch($sformatf("tension got %0d expected %0d",
                                          got.tension, want.tension));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [LANE_W-1:0]    i_cfg_data;
    logic                 push;
    logic                 full;
    logic                 i_req_type;
    logic [63:0]          i_lanes_0_1;
    logic [63:0]          i_lanes_2_3;
    logic [63:0]          i_lanes_4_5;
    logic [63:0]          i_lanes_6_7;
    logic [63:0]          i_lanes_8_9;
    logic [63:0]          i_lanes_10_11;
    logic [63:0]          i_lanes_12_13;
    logic [63:0]          i_lanes_14_15;
    logic [LANE_W-1:0]    i_atom_key;
    logic                 i_last;
    logic                 empty;
    logic                 pop;
    logic [DIST_W-1:0]    o_atom_distance;
    logic                 o_key_matched;
    logic [NUM_W-1:0]     o_atom_number;
    logic                 o_done_res;
    logic [1:0]           o_status;
    logic [NUM_W-1:0]     o_best_index;
    logic [TENSION_W-1:0] o_tension;

    min_search_scoreboard sb = new();
    bit                   src_calm;
    bit                   sink_calm;
    int unsigned          stuck_cycles;
    int unsigned          settings_used;

    masked_lane_distance_min_search #(
        .MAX_ATOMS(MAX_ATOMS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .push            (push),
        .full            (full),
        .i_req_type      (i_req_type),
        .i_lanes_0_1     (i_lanes_0_1),
        .i_lanes_2_3     (i_lanes_2_3),
        .i_lanes_4_5     (i_lanes_4_5),
        .i_lanes_6_7     (i_lanes_6_7),
        .i_lanes_8_9     (i_lanes_8_9),
        .i_lanes_10_11   (i_lanes_10_11),
        .i_lanes_12_13   (i_lanes_12_13),
        .i_lanes_14_15   (i_lanes_14_15),
        .i_atom_key      (i_atom_key),
        .i_last          (i_last),
        .empty           (empty),
        .pop             (pop),
        .o_atom_distance (o_atom_distance),
        .o_key_matched   (o_key_matched),
        .o_atom_number   (o_atom_number),
        .o_done_res      (o_done_res),
        .o_status        (o_status),
        .o_best_index    (o_best_index),
        .o_tension       (o_tension)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Either side now and then switches between random waits and back-to-back traffic.
    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic t_search_item make_item(bit req, t_lanes lanes,
                                               bit [LANE_W-1:0] key, bit last);
        t_search_item it;
        it.req_type = req;
        it.lanes    = lanes;
        it.key      = key;
        it.last     = last;
        return it;
    endfunction

    // Returns base with exactly n lanes changed, chosen at random.
    function automatic t_lanes flip_lanes(t_lanes base, int unsigned n);
        t_lanes          v;
        bit [LANES-1:0]  pick;
        int unsigned     j;
        bit              t;
        v    = base;
        pick = '0;
        for (int i = 0; i < n; i++) pick[i] = 1'b1;
        for (int i = LANES - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = pick[i];
            pick[i] = pick[j];
            pick[j] = t;
        end
        for (int i = 0; i < LANES; i++) begin
            if (pick[i]) v[i] = base[i] ^ ($urandom | (32'd1 << $urandom_range(0, 31)));
        end
        return v;
    endfunction

    function automatic t_lanes random_lanes();
        t_lanes v;
        for (int i = 0; i < LANES; i++) v[i] = $urandom;
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(t_search_item it);
        int unsigned gap;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type    = it.req_type;
        i_lanes_0_1   = {it.lanes[1], it.lanes[0]};
        i_lanes_2_3   = {it.lanes[3], it.lanes[2]};
        i_lanes_4_5   = {it.lanes[5], it.lanes[4]};
        i_lanes_6_7   = {it.lanes[7], it.lanes[6]};
        i_lanes_8_9   = {it.lanes[9], it.lanes[8]};
        i_lanes_10_11 = {it.lanes[11], it.lanes[10]};
        i_lanes_12_13 = {it.lanes[13], it.lanes[12]};
        i_lanes_14_15 = {it.lanes[15], it.lanes[14]};
        i_atom_key    = it.key;
        i_last        = it.last;
        push          = 1'b1;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        sb.absorb_item(it);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, bit [LANE_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic apply_knobs(t_knob_set k);
        write_reg(CFG_SECRET_MASK, k.mask);
        write_reg(CFG_SPIKE_THR, LANE_W'(k.spike));
        write_reg(CFG_REJECT_THR, LANE_W'(k.reject));
        write_reg(CFG_GUARD_EN, LANE_W'(k.guard));
        settings_used++;
    endtask

    function automatic bit [LANE_W-1:0] atom_key_for(bit matching);
        bit [LANE_W-1:0] m;
        m = sb.key_mask;
        if (!matching) return $urandom;
        return (sb.ref_vector[KEY_LANE] & m) | ($urandom & ~m);
    endfunction

    task automatic run_directed();
        t_lanes    q;
        t_knob_set k;
        // Atoms ahead of any query compare against the all-zero reset vector.
        send_item(make_item(REQ_ATOM, '0, '0, 1'b0));
        send_item(make_item(REQ_ATOM, '1, '0, 1'b1));
        // An empty search, then a lone atom whose key cannot match.
        send_item(make_item(REQ_QUERY, '1, '0, 1'b1));
        send_item(make_item(REQ_ATOM, '1, '0, 1'b1));
        q = random_lanes();
        send_item(make_item(REQ_QUERY, q, '1, 1'b0));
        send_item(make_item(REQ_ATOM, q, q[KEY_LANE], 1'b0));
        send_item(make_item(REQ_ATOM, flip_lanes(q, 16), q[KEY_LANE], 1'b0));
        send_item(make_item(REQ_ATOM, q, q[KEY_LANE] ^ 32'd1, 1'b0));
        send_item(make_item(REQ_ATOM, flip_lanes(q, 9), q[KEY_LANE], 1'b1));
        // The search restarts on the same vector: minimum above, then at the rejection level.
        send_item(make_item(REQ_ATOM, flip_lanes(q, 9), q[KEY_LANE], 1'b1));
        send_item(make_item(REQ_ATOM, flip_lanes(q, 8), q[KEY_LANE], 1'b0));
        send_item(make_item(REQ_ATOM, flip_lanes(q, 8), q[KEY_LANE], 1'b1));
        // A query in the middle of a search throws the partial search away.
        send_item(make_item(REQ_ATOM, flip_lanes(q, 4), q[KEY_LANE], 1'b0));
        q = flip_lanes(q, 5);
        send_item(make_item(REQ_QUERY, q, '0, 1'b0));
        send_item(make_item(REQ_ATOM, flip_lanes(q, 6), q[KEY_LANE], 1'b1));

        wait_drained();
        k = '{32'h0, 5'd2, 5'd16, 1'b1};
        apply_knobs(k);
        // One spike only: still resolved.
        send_item(make_item(REQ_ATOM, flip_lanes(q, 1), $urandom, 1'b0));
        send_item(make_item(REQ_ATOM, flip_lanes(q, 5), $urandom, 1'b1));
        // Three spikes: the tally saturates and the guard reports it.
        send_item(make_item(REQ_ATOM, q, $urandom, 1'b0));
        send_item(make_item(REQ_ATOM, flip_lanes(q, 2), $urandom, 1'b0));
        send_item(make_item(REQ_ATOM, flip_lanes(q, 1), $urandom, 1'b1));
    endtask

    // One unit of random traffic: mostly a query followed by a short atom stream.
    task automatic random_burst();
        int unsigned pick;
        int unsigned natoms;
        t_lanes      q;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_item(make_item(1'($urandom_range(0, 1)), random_lanes(), $urandom,
                                1'($urandom_range(0, 1))));
            return;
        end
        natoms = $urandom_range(0, 12);
        if (pick >= 20) begin
            q = random_lanes();
            if (pick < 23) q = '0;
            else if (pick < 26) q = '1;
            send_item(make_item(REQ_QUERY, q, $urandom, natoms == 0));
        end else if (natoms == 0) begin
            natoms = 1;
        end
        for (int k = 0; k < natoms; k++) begin
            // Now and then the stream stops without its last atom.
            if ($urandom_range(0, 39) == 0) break;
            send_item(make_item(REQ_ATOM, flip_lanes(sb.ref_vector, $urandom_range(0, 16)),
                                atom_key_for($urandom_range(0, 99) < 85), k == natoms - 1));
        end
    endtask

    task automatic run_long_search();
        t_knob_set k;
        t_lanes    q;
        t_lanes    v;
        k = '{32'hFFFF_FFFF, 5'd0, 5'd8, 1'b1};
        wait_drained();
        apply_knobs(k);
        q = random_lanes();
        send_item(make_item(REQ_QUERY, q, '0, 1'b0));
        // The atom index and the tension total both saturate; the best atom comes late.
        for (int n = 0; n < LONG_ATOMS; n++) begin
            v = (n == LONG_ATOMS - 4) ? flip_lanes(q, 3) : flip_lanes(q, 16);
            send_item(make_item(REQ_ATOM, v,
                                (n == 500) ? ~q[KEY_LANE] : q[KEY_LANE],
                                n == LONG_ATOMS - 1));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (push && !full) || (pop && !empty)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", STUCK_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        t_result     got;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_gap(sink_calm);
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop = 1'b1;
            @(posedge i_clk);
            while (empty !== 1'b0) @(posedge i_clk);
            got.atom_distance = o_atom_distance;
            got.key_matched   = o_key_matched;
            got.atom_number   = o_atom_number;
            got.done_res      = o_done_res;
            got.status        = t_status'(o_status);
            got.best_index    = o_best_index;
            got.tension       = o_tension;
            sb.check_result(got);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        t_knob_set   k;
        int unsigned start;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_SECRET_MASK;
        i_cfg_data    = '0;
        push          = 1'b0;
        i_req_type    = REQ_QUERY;
        i_lanes_0_1   = '0;
        i_lanes_2_3   = '0;
        i_lanes_4_5   = '0;
        i_lanes_6_7   = '0;
        i_lanes_8_9   = '0;
        i_lanes_10_11 = '0;
        i_lanes_12_13 = '0;
        i_lanes_14_15 = '0;
        i_atom_key    = '0;
        i_last        = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: k = '{32'hFFFF_FFFF, 5'd0, 5'd8, 1'b0};
                1: k = '{32'h0, 5'd16, 5'd16, 1'b1};
                2: k = '{32'h0, 5'd0, 5'd0, 1'b1};
                3: k = '{32'hFFFF_0000, 5'd3, 5'd4, 1'b1};
                default: begin
                    k.mask   = (p % 2) ? $urandom : ($urandom & $urandom & $urandom);
                    k.spike  = DIST_W'($urandom_range(0, 16));
                    k.reject = DIST_W'($urandom_range(0, 16));
                    k.guard  = 1'($urandom_range(0, 1));
                end
            endcase
            wait_drained();
            apply_knobs(k);
            start = sb.items_noted;
            while (sb.items_noted - start < ITEMS_PER_PHASE) begin
                random_burst();
                if ($urandom_range(0, 59) == 0) wait_drained();
            end
        end

        run_long_search();
        wait_drained();

        $display("Covered %0d items (%0d queries) under %0d register settings,",
                 sb.items_noted, sb.queries_noted, settings_used + 1);
        $display("one search past %0d atoms; checked %0d results: resolved %0d, %s %0d, %s %0d.",
                 MAX_ATOMS, sb.results_checked, sb.status_seen[STATUS_RESOLVED],
                 "without match", sb.status_seen[STATUS_NO_MATCH],
                 "spiked", sb.status_seen[STATUS_SPIKE]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/mlds_pkg.sv
rtl/core/mlds_front.sv
rtl/core/mlds_back.sv
rtl/core/masked_lane_distance_min_search.sv
sim/tb_top.sv
